### design/bshf_pkg.sv
// bshf_pkg: shared constants for the binary small hole fill core
// command codes, register indexes, reset values and stream widths
// no dependencies
package bshf_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 12;
    localparam int DIM_W  = 7;
    localparam int HOLE_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE   = 2'd2;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 7'd64;
    localparam logic [HOLE_W-1:0] RST_HOLE   = 13'd5;

endpackage

### design/binary_small_hole_fill_core.sv
// binary_small_hole_fill_core: loads a binary image, fills small 8-connected zero
// components by breadth-first flood through a queue memory, reads back the result
// depends on bshf_pkg
//
// A load is written into the image in the cycle that it is accepted. A read
// registers the addressed pixel, then registers it onto the result stream in the READ
// state. A fill holds off further requests until done: it scans the visit map pixel by
// pixel, then for each component pixel dequeues it and walks its eight neighbor slots,
// with one visit-map read and check for each slot inside the image, and writes each
// pixel of the component back when the component is filled. Every pixel in use must
// be loaded before a fill.
module binary_small_hole_fill_core #(
    parameter int MAX_WIDTH  = bshf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bshf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bshf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bshf_pkg::CFG_DAT_W-1:0]  i_cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // command[1:0], pixel_index[13:2], pixel_value[14], zero[15]
    input  logic [bshf_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_pixel[0], fill_done[1], zero[7:2]
    output logic [bshf_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import bshf_pkg::*;

    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int CNTW  = $clog2(STORE + 1);
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WDW   = $clog2(MAX_WIDTH + 1);
    localparam int HDW   = $clog2(MAX_HEIGHT + 1);
    localparam int QW    = CW + RW;
    localparam int EXW   = 32;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_SCANRD = 4'd2;
    localparam logic [3:0] S_SCANCK = 4'd3;
    localparam logic [3:0] S_DEQ    = 4'd4;
    localparam logic [3:0] S_DEQW   = 4'd5;
    localparam logic [3:0] S_NB     = 4'd6;
    localparam logic [3:0] S_NBCK   = 4'd7;
    localparam logic [3:0] S_DECIDE = 4'd8;
    localparam logic [3:0] S_WBRD   = 4'd9;
    localparam logic [3:0] S_WBW    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic visit_mem  [STORE];
    logic output_mem [STORE];
    logic [QW-1:0] queue_mem [STORE];

    logic [3:0]        r_state, n_state;
    logic [DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [HOLE_W-1:0] r_cfg_hole;
    logic [WDW-1:0]    r_w;
    logic [HDW-1:0]    r_h;
    logic [CNTW-1:0]   r_total;
    logic [CNTW-1:0]   r_scan_pos;
    logic [CW-1:0]     r_scan_col;
    logic [RW-1:0]     r_scan_row;
    logic [CNTW-1:0]   r_head, r_tail, r_k;
    logic [CW-1:0]     r_qcol;
    logic [RW-1:0]     r_qrow;
    logic [3:0]        r_nbr;
    logic [CW-1:0]     r_ncol;
    logic [RW-1:0]     r_nrow;
    logic [AW-1:0]     r_naddr;
    logic              r_visit_q, r_out_q, r_in_store;
    logic [QW-1:0]     r_queue_q;
    logic              r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    logic [CMD_W-1:0] w_cmd;
    logic [IDX_W-1:0] w_idx;
    logic             w_val;
    logic             w_in_store;
    logic [AW-1:0]    w_pix_addr;
    logic             w_accept;
    logic [WDW-1:0]   w_w_eff;
    logic [HDW-1:0]   w_h_eff;
    logic             w_left, w_right, w_up, w_down;
    logic             w_nb_ok;
    logic [CW-1:0]    w_ncol;
    logic [RW-1:0]    w_nrow;
    logic [CNTW-1:0]  w_naddr_full;
    logic [CW-1:0]    w_dq_col;
    logic [RW-1:0]    w_dq_row;
    logic [AW-1:0]    w_wb_addr;
    logic             w_scan_last_row;

    assign w_cmd      = s_axis_tdata[1:0];
    assign w_idx      = s_axis_tdata[13:2];
    assign w_val      = s_axis_tdata[14];
    assign w_in_store = EXW'(w_idx) < EXW'(STORE);
    assign w_pix_addr = AW'(w_idx);

    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_w_eff = WDW'(1);
        end else if (EXW'(r_cfg_w) > EXW'(MAX_WIDTH)) begin
            w_w_eff = WDW'(MAX_WIDTH);
        end else begin
            w_w_eff = WDW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            w_h_eff = HDW'(1);
        end else if (EXW'(r_cfg_h) > EXW'(MAX_HEIGHT)) begin
            w_h_eff = HDW'(MAX_HEIGHT);
        end else begin
            w_h_eff = HDW'(r_cfg_h);
        end
    end

    // neighbor slot decode
    assign w_left  = r_qcol != '0;
    assign w_right = EXW'(r_qcol) + 1 < EXW'(r_w);
    assign w_up    = r_qrow != '0;
    assign w_down  = EXW'(r_qrow) + 1 < EXW'(r_h);

    always_comb begin
        w_ncol  = r_qcol;
        w_nrow  = r_qrow;
        w_nb_ok = 1'b0;
        case (r_nbr)
            4'd0: begin w_ncol = r_qcol - 1'b1; w_nb_ok = w_left; end
            4'd1: begin
                w_ncol = r_qcol - 1'b1; w_nrow = r_qrow - 1'b1; w_nb_ok = w_left && w_up;
            end
            4'd2: begin
                w_ncol = r_qcol - 1'b1; w_nrow = r_qrow + 1'b1; w_nb_ok = w_left && w_down;
            end
            4'd3: begin w_nrow = r_qrow - 1'b1; w_nb_ok = w_up; end
            4'd4: begin w_nrow = r_qrow + 1'b1; w_nb_ok = w_down; end
            4'd5: begin w_ncol = r_qcol + 1'b1; w_nb_ok = w_right; end
            4'd6: begin
                w_ncol = r_qcol + 1'b1; w_nrow = r_qrow - 1'b1; w_nb_ok = w_right && w_up;
            end
            4'd7: begin
                w_ncol = r_qcol + 1'b1; w_nrow = r_qrow + 1'b1; w_nb_ok = w_right && w_down;
            end
            default: w_nb_ok = 1'b0;
        endcase
    end

    assign w_naddr_full = CNTW'(EXW'(w_ncol) * EXW'(r_h) + EXW'(w_nrow));
    assign w_dq_col     = r_queue_q[QW-1:RW];
    assign w_dq_row     = r_queue_q[RW-1:0];
    assign w_wb_addr    = AW'(EXW'(w_dq_col) * EXW'(r_h) + EXW'(w_dq_row));
    assign w_scan_last_row = EXW'(r_scan_row) + 1 == EXW'(r_h);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_cmd == CMD_READ) begin
                    n_state = S_READ;
                end else if (w_accept && w_cmd == CMD_FILL) begin
                    n_state = S_SCANRD;
                end
            end
            S_READ:   n_state = S_IDLE;
            S_SCANRD: n_state = (r_scan_pos == r_total) ? S_DONE : S_SCANCK;
            S_SCANCK: n_state = r_visit_q ? S_SCANRD : S_DEQ;
            S_DEQ:    n_state = (r_head == r_tail) ? S_DECIDE : S_DEQW;
            S_DEQW:   n_state = S_NB;
            S_NB: begin
                if (r_nbr == 4'd8) begin
                    n_state = S_DEQ;
                end else if (w_nb_ok) begin
                    n_state = S_NBCK;
                end
            end
            S_NBCK:   n_state = S_NB;
            S_DECIDE: n_state = (EXW'(r_tail) <= EXW'(r_cfg_hole)) ? S_WBRD : S_SCANRD;
            S_WBRD:   n_state = (r_k == r_tail) ? S_SCANRD : S_WBW;
            S_WBW:    n_state = S_WBRD;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_accept && w_cmd == CMD_LOAD && w_in_store) begin
            visit_mem[w_pix_addr]  <= w_val;
            output_mem[w_pix_addr] <= w_val;
        end
        if (r_state == S_SCANCK && !r_visit_q) begin
            visit_mem[r_scan_pos[AW-1:0]] <= 1'b1;
            queue_mem[0]                  <= {r_scan_col, r_scan_row};
        end
        if (r_state == S_NBCK && !r_visit_q) begin
            visit_mem[r_naddr]          <= 1'b1;
            queue_mem[r_tail[AW-1:0]]   <= {r_ncol, r_nrow};
        end
        if (r_state == S_WBW) begin
            output_mem[w_wb_addr] <= 1'b1;
        end
        if (r_state == S_SCANRD) begin
            r_visit_q <= visit_mem[r_scan_pos[AW-1:0]];
        end else if (r_state == S_NB) begin
            r_visit_q <= visit_mem[w_naddr_full[AW-1:0]];
        end
        if (r_state == S_WBRD) begin
            r_queue_q <= queue_mem[r_k[AW-1:0]];
        end else begin
            r_queue_q <= queue_mem[r_head[AW-1:0]];
        end
        r_out_q <= output_mem[w_pix_addr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_store <= w_in_store;
            r_w        <= w_w_eff;
            r_h        <= w_h_eff;
            r_total    <= CNTW'(EXW'(w_w_eff) * EXW'(w_h_eff));
        end
        if (r_state == S_DEQW) begin
            r_qcol <= w_dq_col;
            r_qrow <= w_dq_row;
        end
        if (r_state == S_NB) begin
            r_ncol  <= w_ncol;
            r_nrow  <= w_nrow;
            r_naddr <= w_naddr_full[AW-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_w    <= RST_WIDTH;
            r_cfg_h    <= RST_HEIGHT;
            r_cfg_hole <= RST_HOLE;
            r_scan_pos <= '0;
            r_scan_col <= '0;
            r_scan_row <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_k        <= '0;
            r_nbr      <= '0;
            r_m_valid  <= 1'b0;
            r_m_data   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_cfg_w    <= i_cfg_wr_data[DIM_W-1:0];
                    REG_HEIGHT: r_cfg_h    <= i_cfg_wr_data[DIM_W-1:0];
                    REG_HOLE:   r_cfg_hole <= i_cfg_wr_data;
                    default:    r_cfg_hole <= r_cfg_hole;
                endcase
            end
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_cmd == CMD_FILL) begin
                        r_scan_pos <= '0;
                        r_scan_col <= '0;
                        r_scan_row <= '0;
                    end
                end
                S_READ: begin
                    r_m_valid <= 1'b1;
                    r_m_data  <= M_DATA_W'({1'b0, r_in_store & r_out_q});
                end
                S_SCANCK: begin
                    if (r_visit_q) begin
                        r_scan_pos <= r_scan_pos + 1'b1;
                        if (w_scan_last_row) begin
                            r_scan_row <= '0;
                            r_scan_col <= r_scan_col + 1'b1;
                        end else begin
                            r_scan_row <= r_scan_row + 1'b1;
                        end
                    end else begin
                        r_head <= '0;
                        r_tail <= CNTW'(1);
                    end
                end
                S_DEQW: begin
                    r_head <= r_head + 1'b1;
                    r_nbr  <= '0;
                end
                S_NB: begin
                    if (r_nbr != 4'd8 && !w_nb_ok) begin
                        r_nbr <= r_nbr + 1'b1;
                    end
                end
                S_NBCK: begin
                    r_nbr <= r_nbr + 1'b1;
                    if (!r_visit_q) begin
                        r_tail <= r_tail + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_k <= '0;
                    if (EXW'(r_tail) > EXW'(r_cfg_hole)) begin
                        r_scan_pos <= r_scan_pos + 1'b1;
                        if (w_scan_last_row) begin
                            r_scan_row <= '0;
                            r_scan_col <= r_scan_col + 1'b1;
                        end else begin
                            r_scan_row <= r_scan_row + 1'b1;
                        end
                    end
                end
                S_WBRD: begin
                    if (r_k == r_tail) begin
                        r_scan_pos <= r_scan_pos + 1'b1;
                        if (w_scan_last_row) begin
                            r_scan_row <= '0;
                            r_scan_col <= r_scan_col + 1'b1;
                        end else begin
                            r_scan_row <= r_scan_row + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DONE: begin
                    r_m_valid <= 1'b1;
                    r_m_data  <= M_DATA_W'(2'b10);
                end
                default: r_nbr <= r_nbr;
            endcase
        end
    end

endmodule
